@@ rtl/core/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam logic [0:0] CMD_ALLOC = 1'b0;
    localparam logic [0:0] CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_SCAN,
        S_A_RD,
        S_A_UNL,
        S_A_UNLP,
        S_A_UNLN,
        S_A_SPLIT,
        S_A_SPLITH,
        S_A_MARK,
        S_F_RD,
        S_F_CHK,
        S_F_BRD,
        S_F_BCHK,
        S_F_UNLP,
        S_F_UNLN,
        S_F_PUSH,
        S_F_PUSHH,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/bpa_mem.sv @@
// ----------------------------------------------------------------------------
// bpa_mem
// Per-page store: next link, prev link, status and allocated order in one
// word, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module bpa_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 28
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/core/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator: per-order doubly linked free lists held in a page
// store, walked by a sequencer.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Fields
// in      | input     | i_valid / o_stall      | cmd, page_count, free_page
// out     | output    | o_valid / i_stall      | status, block_page, block_order
//
// One request at a time. An allocate scans the free lists from the needed order
// up, unlinks the block found, splits it down and marks it allocated; a free
// checks the page, merges it with each free buddy and pushes the result. A bad
// free or an oversized request changes no list. After reset a fill pass writes
// every page entry, during which no request is taken. A result waits in the
// output register while i_stall is high; no new request is taken until it goes.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int PAGE_COUNT = 1024,
    parameter int TOP_ORDER  = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [0:0] i_cmd,
    input  logic [5:0] i_page_count,
    input  logic [9:0] i_free_page,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [9:0] o_block_page,
    output logic [2:0] o_block_order
);
    import bpa_pkg::*;

    localparam int AW = $clog2(PAGE_COUNT);
    localparam int LW = AW + 1;
    localparam int SW = $clog2(TOP_ORDER + 3);
    localparam int OW = $clog2(TOP_ORDER + 1);
    localparam int DW = 2 * LW + SW + OW;
    localparam int NL = TOP_ORDER + 1;
    localparam int BLK = 1 << TOP_ORDER;
    localparam logic [LW-1:0] NIL = '1;
    localparam logic [SW-1:0] PS_INSIDE = SW'(TOP_ORDER + 1);
    localparam logic [SW-1:0] PS_ALLOC  = SW'(TOP_ORDER + 2);
    localparam logic [AW-1:0] TOP_BLK = AW'(((PAGE_COUNT / BLK) - 1) * BLK);

    typedef struct packed {
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
        logic [SW-1:0] st;
        logic [OW-1:0] ao;
    } t_ent;

    t_state r_state, n_state;
    logic [LW-1:0] r_head [NL];
    logic [LW-1:0] n_head [NL];
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_bud, n_bud;
    logic [OW-1:0] r_ord, n_ord;
    logic [OW-1:0] r_need, n_need;
    logic [LW-1:0] r_n, n_n;
    logic [LW-1:0] r_p, n_p;
    logic          r_cmd, n_cmd;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ostat, n_ostat;
    logic [AW-1:0] r_opage, n_opage;
    logic [OW-1:0] r_oord, n_oord;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_ent          wd, rd;
    logic [DW-1:0] rdata;

    bpa_mem #(.DEPTH(PAGE_COUNT), .AW(AW), .DW(DW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wd),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );
    assign rd = t_ent'(rdata);

    function automatic logic [OW-1:0] f_need(input logic [5:0] c);
        logic [OW-1:0] r;
        r = '0;
        for (int k = 0; k < NL; k++) begin
            if ((7'd1 << k) < {1'b0, c}) r = OW'(k + 1);
        end
        return r;
    endfunction

    logic [AW-1:0] split_pg;
    logic [AW-1:0] ord_bit;
    assign ord_bit  = AW'(1) << r_ord;
    assign split_pg = r_cur + (AW'(1) << (r_ord - OW'(1)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     if (r_ptr == AW'(PAGE_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    if (i_cmd == CMD_FREE) begin
                        n_state = ({1'b0, i_free_page} >= 11'(PAGE_COUNT)) ? S_DONE : S_F_RD;
                    end else begin
                        n_state = ({1'b0, i_page_count} > 7'(BLK)) ? S_DONE : S_A_SCAN;
                    end
                end
            end
            S_A_SCAN: begin
                if (r_head[r_ord] != NIL) n_state = S_A_RD;
                else if (r_ord == OW'(TOP_ORDER)) n_state = S_DONE;
            end
            S_A_RD:     n_state = S_A_UNL;
            S_A_UNL:    n_state = S_A_UNLP;
            S_A_UNLP:   n_state = S_A_UNLN;
            S_A_UNLN:   n_state = (r_ord > r_need) ? S_A_SPLIT : S_A_MARK;
            S_A_SPLIT:  n_state = S_A_SPLITH;
            S_A_SPLITH: n_state = (r_ord > r_need) ? S_A_SPLIT : S_A_MARK;
            S_A_MARK:   n_state = S_DONE;
            S_F_RD:     n_state = S_F_CHK;
            S_F_CHK:    n_state = (rd.st != PS_ALLOC) ? S_DONE : S_F_BRD;
            S_F_BRD: begin
                if (r_ord >= OW'(TOP_ORDER) ||
                    {1'b0, r_cur ^ ord_bit} >= LW'(PAGE_COUNT)) n_state = S_F_PUSH;
                else n_state = S_F_BCHK;
            end
            S_F_BCHK:   n_state = (rd.st == SW'(r_ord)) ? S_F_UNLP : S_F_PUSH;
            S_F_UNLP:   n_state = S_F_UNLN;
            S_F_UNLN:   n_state = S_F_BRD;
            S_F_PUSH:   n_state = S_F_PUSHH;
            S_F_PUSHH:  n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_ptr    = r_ptr;
        n_cur    = r_cur;
        n_bud    = r_bud;
        n_ord    = r_ord;
        n_need   = r_need;
        n_n      = r_n;
        n_p      = r_p;
        n_cmd    = r_cmd;
        n_ostat  = r_ostat;
        n_opage  = r_opage;
        n_oord   = r_oord;
        n_ovalid = r_ovalid && i_stall;
        we       = 1'b0;
        waddr    = r_cur;
        raddr    = r_cur;
        wd       = '{nxt: NIL, prv: NIL, st: PS_INSIDE, ao: '0};
        case (r_state)
            S_INIT: begin
                we    = 1'b1;
                waddr = r_ptr;
                n_ptr = r_ptr + AW'(1);
                if (r_ptr[TOP_ORDER-1:0] == '0) begin
                    wd.st  = SW'(TOP_ORDER);
                    wd.nxt = (r_ptr == '0) ? NIL : {1'b0, r_ptr - AW'(BLK)};
                    wd.prv = (r_ptr == TOP_BLK) ? NIL : {1'b0, r_ptr + AW'(BLK)};
                end
            end
            S_IDLE: begin
                raddr = i_free_page;
                if (i_valid && !r_ovalid) begin
                    n_cmd   = i_cmd;
                    n_cur   = i_free_page;
                    n_need  = f_need(i_page_count);
                    n_ord   = f_need(i_page_count);
                    n_ostat = ST_OK;
                    n_opage = '0;
                    n_oord  = '0;
                end
            end
            S_A_SCAN: begin
                if (r_head[r_ord] != NIL) n_cur = r_head[r_ord][AW-1:0];
                else if (r_ord != OW'(TOP_ORDER)) n_ord = r_ord + OW'(1);
                else n_ostat = ST_NO_BLOCK;
            end
            S_A_RD: raddr = r_cur;
            S_A_UNL: begin
                n_n = rd.nxt;
                n_p = rd.prv;
                n_head[r_ord] = rd.nxt;
                we = 1'b1;
                wd = '{nxt: NIL, prv: NIL, st: rd.st, ao: rd.ao};
                raddr = rd.nxt[AW-1:0];
            end
            S_A_UNLP: raddr = r_n[AW-1:0];
            S_A_UNLN: begin
                if (r_n != NIL) begin
                    we = 1'b1;
                    waddr = r_n[AW-1:0];
                    wd = rd;
                    wd.prv = NIL;
                end
            end
            S_A_SPLIT: begin
                we = 1'b1;
                waddr = split_pg;
                wd = '{nxt: r_head[r_ord - OW'(1)], prv: NIL,
                       st: SW'(r_ord - OW'(1)), ao: '0};
                raddr = r_head[r_ord - OW'(1)][AW-1:0];
                n_bud = split_pg;
                n_ord = r_ord - OW'(1);
            end
            S_A_SPLITH: begin
                if (r_head[r_ord] != NIL) begin
                    we = 1'b1;
                    waddr = r_head[r_ord][AW-1:0];
                    wd = rd;
                    wd.prv = {1'b0, r_bud};
                end
                n_head[r_ord] = {1'b0, r_bud};
            end
            S_A_MARK: begin
                we = 1'b1;
                waddr = r_cur;
                wd = '{nxt: NIL, prv: NIL, st: PS_ALLOC, ao: r_need};
                n_opage = r_cur;
                n_oord  = r_need;
            end
            S_F_RD: raddr = r_cur;
            S_F_CHK: begin
                if (rd.st != PS_ALLOC) begin
                    n_ostat = ST_BAD_FREE;
                end else begin
                    n_ord = (rd.ao > OW'(TOP_ORDER)) ? OW'(TOP_ORDER) : rd.ao;
                    n_bud = r_cur;
                    we = 1'b1;
                    wd = '{nxt: rd.nxt, prv: rd.prv, st: PS_INSIDE, ao: '0};
                end
            end
            S_F_BRD: begin
                raddr = r_cur ^ ord_bit;
                n_bud = r_cur ^ ord_bit;
            end
            S_F_BCHK: begin
                n_n = rd.nxt;
                n_p = rd.prv;
                we = 1'b1;
                waddr = r_bud;
                wd = '{nxt: NIL, prv: NIL, st: PS_INSIDE, ao: rd.ao};
                if (rd.st == SW'(r_ord)) begin
                    if (rd.prv == NIL) n_head[r_ord] = rd.nxt;
                    raddr = rd.prv[AW-1:0];
                end else begin
                    we = 1'b0;
                end
            end
            S_F_UNLP: begin
                if (r_p != NIL) begin
                    we = 1'b1;
                    waddr = r_p[AW-1:0];
                    wd = rd;
                    wd.nxt = r_n;
                end
                raddr = r_n[AW-1:0];
            end
            S_F_UNLN: begin
                if (r_n != NIL) begin
                    we = 1'b1;
                    waddr = r_n[AW-1:0];
                    wd = rd;
                    wd.prv = r_p;
                end
                if (r_bud < r_cur) n_cur = r_bud;
                n_ord = r_ord + OW'(1);
            end
            S_F_PUSH: begin
                we = 1'b1;
                waddr = r_cur;
                wd = '{nxt: r_head[r_ord], prv: NIL, st: SW'(r_ord), ao: '0};
                raddr = r_head[r_ord][AW-1:0];
            end
            S_F_PUSHH: begin
                if (r_head[r_ord] != NIL) begin
                    we = 1'b1;
                    waddr = r_head[r_ord][AW-1:0];
                    wd = rd;
                    wd.prv = {1'b0, r_cur};
                end
                n_head[r_ord] = {1'b0, r_cur};
                n_opage = r_cur;
                n_oord  = r_ord;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                if (r_cmd == CMD_ALLOC && r_ostat == ST_OK &&
                    r_oord == '0 && r_opage == '0 && r_need != '0 &&
                    r_state == S_DONE) begin
                    n_ostat = r_ostat;
                end
            end
            default: ;
        endcase
        if (r_state == S_IDLE && i_valid && !r_ovalid) begin
            if (i_cmd == CMD_FREE && {1'b0, i_free_page} >= 11'(PAGE_COUNT))
                n_ostat = ST_BAD_FREE;
            if (i_cmd == CMD_ALLOC && {1'b0, i_page_count} > 7'(BLK))
                n_ostat = ST_TOO_BIG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NL; k++) begin
                r_head[k] <= (k == TOP_ORDER) ? {1'b0, TOP_BLK} : NIL;
            end
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_ovalid <= n_ovalid;
            r_head   <= n_head;
        end
        r_cur   <= n_cur;
        r_bud   <= n_bud;
        r_ord   <= n_ord;
        r_need  <= n_need;
        r_n     <= n_n;
        r_p     <= n_p;
        r_cmd   <= n_cmd;
        r_ostat <= n_ostat;
        r_opage <= n_opage;
        r_oord  <= n_oord;
    end

    assign o_stall       = (r_state != S_IDLE) || r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostat;
    assign o_block_page  = 10'(r_opage);
    assign o_block_order = 3'(r_oord);
endmodule
